>>> hdl/rmq_pkg.sv
// Shared types, constants and codes for the range-minimum block.
package rmq_pkg;

  // Default sizes of the stores.
  localparam int unsigned DEF_MAX_ELEMS   = 1024;
  localparam int unsigned DEF_MAX_BLOCKS  = 64;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  // Fixed field widths.
  localparam int unsigned IDX_W     = 11;  // element / block indices, counts
  localparam int unsigned POS_W     = 10;  // left / right index fields
  localparam int unsigned OUT_W     = 32;  // data_value and min_value
  localparam int unsigned CFG_IDX_W = 2;

  // Register indices on the config port.
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BLK_SIZE   = CFG_IDX_W'(1);

  // Register reset values.
  localparam logic [IDX_W-1:0] ELEM_COUNT_RST = IDX_W'(1024);
  localparam logic [IDX_W-1:0] BLK_SIZE_RST   = IDX_W'(32);

  // Read source for the compare unit.
  localparam logic SRC_ELEM = 1'b0;
  localparam logic SRC_BMIN = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_QUERY   = 2'd1,
    OP_UPDATE  = 2'd2,
    OP_INVALID = 2'd3
  } rmq_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT,
    ST_DISPATCH,
    ST_LD_RD,
    ST_LD_CMP,
    ST_LD_WR,
    ST_Q_DIVR,
    ST_Q_PLAN,
    ST_UP_PLAN,
    ST_SCAN,
    ST_NEXT,
    ST_UP_WR,
    ST_DONE,
    ST_FAIL
  } rmq_state_e;

  typedef enum logic [1:0] {
    PH_LEFT,
    PH_BLOCKS,
    PH_RIGHT,
    PH_UPD
  } rmq_phase_e;

  typedef struct packed {
    rmq_op_e          op;
    logic [POS_W-1:0] left_index;
    logic [POS_W-1:0] right_index;
    logic [OUT_W-1:0] data_value;
  } rmq_cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0] min_value;
    logic             error;
  } rmq_res_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] dividend;
    logic [IDX_W-1:0] divisor;
  } rmq_div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quo;
    logic [IDX_W-1:0] rem;
  } rmq_div_rsp_t;

  typedef struct packed {
    logic             val_ld;
    logic             elem_we;
    logic             elem_re;
    logic [IDX_W-1:0] elem_addr;
    logic             bmin_we;
    logic             bmin_re;
    logic [IDX_W-1:0] bmin_addr;
    logic             min_init;
    logic             min_ld_val;
    logic             cmp_en;
    logic             cmp_src;
  } rmq_dp_ctl_t;

endpackage

>>> hdl/rmq_div.sv
// Restoring divider, one quotient bit per cycle.
module rmq_div
  import rmq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rmq_div_req_t req_i,
  output rmq_div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(IDX_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] quo_q, quo_d;
  logic [IDX_W-1:0] rem_q, rem_d;
  logic [IDX_W-1:0] dsr_q, dsr_d;
  logic [IDX_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, quo_q[IDX_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? IDX_W'(trial - {1'b0, dsr_q}) : IDX_W'(trial);
      quo_d = {quo_q[IDX_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(IDX_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> hdl/rmq_dp.sv
// Element and block-minimum stores with the shared minimum compare unit.
module rmq_dp
  import rmq_pkg::*;
#(
  parameter int unsigned MAX_ELEMS   = DEF_MAX_ELEMS,
  parameter int unsigned MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  rmq_dp_ctl_t            ctl_i,
  input  logic [OUT_W-1:0]       data_i,
  output logic [VALUE_WIDTH-1:0] min_o
);

  localparam int unsigned AW = $clog2(MAX_ELEMS);
  localparam int unsigned BW = $clog2(MAX_BLOCKS);

  logic [VALUE_WIDTH-1:0] elem_mem [MAX_ELEMS];
  logic [VALUE_WIDTH-1:0] bmin_mem [MAX_BLOCKS];
  logic [VALUE_WIDTH-1:0] elem_rd_q;
  logic [VALUE_WIDTH-1:0] bmin_rd_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [VALUE_WIDTH-1:0] min_q, min_d;
  logic [VALUE_WIDTH-1:0] cand;

  always_ff @(posedge clk_i) begin
    if (ctl_i.elem_we) begin
      elem_mem[AW'(ctl_i.elem_addr)] <= val_q;
    end
    if (ctl_i.elem_re) begin
      elem_rd_q <= elem_mem[AW'(ctl_i.elem_addr)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.bmin_we) begin
      bmin_mem[BW'(ctl_i.bmin_addr)] <= min_q;
    end
    if (ctl_i.bmin_re) begin
      bmin_rd_q <= bmin_mem[BW'(ctl_i.bmin_addr)];
    end
  end

  assign cand = (ctl_i.cmp_src == SRC_BMIN) ? bmin_rd_q : elem_rd_q;

  always_comb begin
    min_d = min_q;
    if (ctl_i.min_init) begin
      min_d = '1;
    end else if (ctl_i.min_ld_val) begin
      min_d = val_q;
    end else if (ctl_i.cmp_en && (cand < min_q)) begin
      min_d = cand;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.val_ld) begin
      val_q <= VALUE_WIDTH'(data_i);
    end
    min_q <= min_d;
  end

  assign min_o = min_q;

endmodule

>>> hdl/rmq_ctrl.sv
// Sequencer: validity checks, divider use, scan planning and result word.
module rmq_ctrl
  import rmq_pkg::*;
#(
  parameter int unsigned MAX_ELEMS   = DEF_MAX_ELEMS,
  parameter int unsigned MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  rmq_cmd_t               cmd_i,
  output logic                   busy_o,
  input  logic [IDX_W-1:0]       elem_count_i,
  input  logic [IDX_W-1:0]       blk_size_i,
  input  logic [VALUE_WIDTH-1:0] min_i,
  input  rmq_div_rsp_t           div_rsp_i,
  output rmq_div_req_t           div_req_o,
  output rmq_dp_ctl_t            dp_ctl_o,
  output logic                   result_valid_o,
  output rmq_res_t               result_o
);

  rmq_state_e       state_q, state_d;
  rmq_state_e       after_q, after_d;
  rmq_phase_e       phase_q, phase_d;
  logic [IDX_W-1:0] ld_cnt_q, ld_cnt_d;
  logic             pend_q, pend_d;
  logic             pend_src_q, pend_src_d;
  logic             res_vld_q, res_vld_d;
  rmq_res_t         res_q, res_d;

  rmq_op_e          op_q, op_d;
  logic [IDX_W-1:0] left_q, left_d;
  logic [IDX_W-1:0] right_q, right_d;
  logic [IDX_W-1:0] blk_l_q, blk_l_d;
  logic [IDX_W-1:0] blk_r_q, blk_r_d;
  logic [IDX_W-1:0] base_l_q, base_l_d;
  logic [IDX_W-1:0] base_r_q, base_r_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] end_q, end_d;
  logic             pos_zero_q, pos_zero_d;

  logic [IDX_W:0]   blk_total;
  logic [IDX_W:0]   upd_hi;
  logic [IDX_W-1:0] upd_lo;

  // ceil(elem_count / blk_size) from the divider result
  assign blk_total = {1'b0, div_rsp_i.quo} + (IDX_W + 1)'(div_rsp_i.rem != '0);
  assign upd_lo    = left_q - div_rsp_i.rem;
  assign upd_hi    = ({1'b0, upd_lo} + {1'b0, blk_size_i}) > {1'b0, elem_count_i}
                   ? {1'b0, elem_count_i}
                   : {1'b0, upd_lo} + {1'b0, blk_size_i};

  always_comb begin
    state_d    = state_q;
    after_d    = after_q;
    phase_d    = phase_q;
    ld_cnt_d   = ld_cnt_q;
    pend_d     = 1'b0;
    pend_src_d = pend_src_q;
    res_vld_d  = 1'b0;
    res_d      = res_q;
    op_d       = op_q;
    left_d     = left_q;
    right_d    = right_q;
    blk_l_d    = blk_l_q;
    blk_r_d    = blk_r_q;
    base_l_d   = base_l_q;
    base_r_d   = base_r_q;
    cur_d      = cur_q;
    end_d      = end_q;
    pos_zero_d = pos_zero_q;

    div_req_o.start    = 1'b0;
    div_req_o.dividend = elem_count_i;
    div_req_o.divisor  = blk_size_i;

    dp_ctl_o            = '0;
    dp_ctl_o.elem_addr  = cur_q;
    dp_ctl_o.bmin_addr  = cur_q;
    dp_ctl_o.cmp_en     = pend_q;
    dp_ctl_o.cmp_src    = pend_src_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d            = cmd_i.op;
          left_d          = IDX_W'(cmd_i.left_index);
          right_d         = IDX_W'(cmd_i.right_index);
          dp_ctl_o.val_ld = 1'b1;
          state_d         = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (op_q == OP_INVALID || elem_count_i == '0 || blk_size_i == '0 ||
            32'(elem_count_i) > MAX_ELEMS) begin
          state_d = ST_FAIL;
        end else begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = elem_count_i;
          after_d            = ST_DISPATCH;
          state_d            = ST_WAIT;
        end
      end

      ST_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = after_q;
        end
      end

      ST_DISPATCH: begin
        if (32'(blk_total) > MAX_BLOCKS) begin
          state_d = ST_FAIL;
        end else begin
          case (op_q)
            OP_LOAD: begin
              if (ld_cnt_q >= elem_count_i) begin
                state_d = ST_FAIL;
              end else begin
                div_req_o.start    = 1'b1;
                div_req_o.dividend = ld_cnt_q;
                after_d            = ST_LD_RD;
                state_d            = ST_WAIT;
              end
            end
            OP_QUERY: begin
              if (left_q > right_q || right_q >= elem_count_i) begin
                state_d = ST_FAIL;
              end else begin
                div_req_o.start    = 1'b1;
                div_req_o.dividend = left_q;
                after_d            = ST_Q_DIVR;
                state_d            = ST_WAIT;
              end
            end
            OP_UPDATE: begin
              if (left_q >= elem_count_i) begin
                state_d = ST_FAIL;
              end else begin
                dp_ctl_o.elem_we   = 1'b1;
                dp_ctl_o.elem_addr = left_q;
                div_req_o.start    = 1'b1;
                div_req_o.dividend = left_q;
                after_d            = ST_UP_PLAN;
                state_d            = ST_WAIT;
              end
            end
            default: begin
              state_d = ST_FAIL;
            end
          endcase
        end
      end

      // load: append element, fold into the block's running minimum
      ST_LD_RD: begin
        dp_ctl_o.elem_we    = 1'b1;
        dp_ctl_o.elem_addr  = ld_cnt_q;
        dp_ctl_o.bmin_re    = 1'b1;
        dp_ctl_o.bmin_addr  = div_rsp_i.quo;
        dp_ctl_o.min_ld_val = 1'b1;
        blk_l_d             = div_rsp_i.quo;
        pos_zero_d          = div_rsp_i.rem == '0;
        state_d             = ST_LD_CMP;
      end

      ST_LD_CMP: begin
        dp_ctl_o.cmp_en  = !pos_zero_q;
        dp_ctl_o.cmp_src = SRC_BMIN;
        state_d          = ST_LD_WR;
      end

      ST_LD_WR: begin
        dp_ctl_o.bmin_we   = 1'b1;
        dp_ctl_o.bmin_addr = blk_l_q;
        ld_cnt_d           = ld_cnt_q + IDX_W'(1);
        state_d            = ST_IDLE;
      end

      ST_Q_DIVR: begin
        blk_l_d            = div_rsp_i.quo;
        base_l_d           = left_q - div_rsp_i.rem;
        div_req_o.start    = 1'b1;
        div_req_o.dividend = right_q;
        after_d            = ST_Q_PLAN;
        state_d            = ST_WAIT;
      end

      ST_Q_PLAN: begin
        blk_r_d           = div_rsp_i.quo;
        base_r_d          = right_q - div_rsp_i.rem;
        dp_ctl_o.min_init = 1'b1;
        cur_d             = left_q;
        end_d             = (blk_l_q == div_rsp_i.quo) ? right_q
                          : base_l_q + blk_size_i - IDX_W'(1);
        phase_d           = PH_LEFT;
        state_d           = ST_SCAN;
      end

      ST_UP_PLAN: begin
        blk_l_d           = div_rsp_i.quo;
        dp_ctl_o.min_init = 1'b1;
        cur_d             = upd_lo;
        end_d             = IDX_W'(upd_hi - (IDX_W + 1)'(1));
        phase_d           = PH_UPD;
        state_d           = ST_SCAN;
      end

      // one read per cycle, compared in the cycle after the read
      ST_SCAN: begin
        pend_d = 1'b1;
        if (phase_q == PH_BLOCKS) begin
          dp_ctl_o.bmin_re = 1'b1;
          pend_src_d       = SRC_BMIN;
        end else begin
          dp_ctl_o.elem_re = 1'b1;
          pend_src_d       = SRC_ELEM;
        end
        if (cur_q == end_q) begin
          state_d = ST_NEXT;
        end else begin
          cur_d = cur_q + IDX_W'(1);
        end
      end

      ST_NEXT: begin
        case (phase_q)
          PH_LEFT: begin
            if (blk_l_q == blk_r_q) begin
              state_d = ST_DONE;
            end else if ((blk_l_q + IDX_W'(1)) < blk_r_q) begin
              cur_d   = blk_l_q + IDX_W'(1);
              end_d   = blk_r_q - IDX_W'(1);
              phase_d = PH_BLOCKS;
              state_d = ST_SCAN;
            end else begin
              cur_d   = base_r_q;
              end_d   = right_q;
              phase_d = PH_RIGHT;
              state_d = ST_SCAN;
            end
          end
          PH_BLOCKS: begin
            cur_d   = base_r_q;
            end_d   = right_q;
            phase_d = PH_RIGHT;
            state_d = ST_SCAN;
          end
          PH_RIGHT: begin
            state_d = ST_DONE;
          end
          PH_UPD: begin
            state_d = ST_UP_WR;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      ST_UP_WR: begin
        dp_ctl_o.bmin_we   = 1'b1;
        dp_ctl_o.bmin_addr = blk_l_q;
        state_d            = ST_IDLE;
      end

      ST_DONE: begin
        res_vld_d       = 1'b1;
        res_d.min_value = OUT_W'(min_i);
        res_d.error     = 1'b0;
        state_d         = ST_IDLE;
      end

      ST_FAIL: begin
        res_vld_d       = 1'b1;
        res_d.min_value = '0;
        res_d.error     = 1'b1;
        state_d         = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      after_q    <= ST_IDLE;
      phase_q    <= PH_LEFT;
      ld_cnt_q   <= '0;
      pend_q     <= 1'b0;
      pend_src_q <= SRC_ELEM;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      after_q    <= after_d;
      phase_q    <= phase_d;
      ld_cnt_q   <= ld_cnt_d;
      pend_q     <= pend_d;
      pend_src_q <= pend_src_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    op_q       <= op_d;
    left_q     <= left_d;
    right_q    <= right_d;
    blk_l_q    <= blk_l_d;
    blk_r_q    <= blk_r_d;
    base_l_q   <= base_l_d;
    base_r_q   <= base_r_d;
    cur_q      <= cur_d;
    end_q      <= end_d;
    pos_zero_q <= pos_zero_d;
  end

  assign busy_o         = state_q != ST_IDLE;
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

>>> hdl/range_min_sqrt_blocks_top.sv
// Top level of the range-minimum block: config registers and unit wiring.
//
// Range-minimum engine over an array split into blocks of a configured size,
// with one stored minimum per block. A word is taken when start_i
// is high and busy_o is low; busy_o then stays high until the word is done,
// and the next word may start in the cycle after busy_o falls. Loads and
// updates return nothing on success; a query, and any failing word, puts
// one result word on result_o with result_valid_o high for exactly one
// cycle, the first cycle after busy_o falls. There is no backpressure on the
// result side: the receiver must take it in that cycle. Timing is set by one
// shared 11-bit restoring divider and one compare unit that reads one stored
// entry per cycle from single-port memories. Every word starts with the
// configuration check, which uses one division. A load then takes a second
// division and a read, compare and write of the block minimum. An update
// writes the element, takes a second division, reads every entry of its block
// and writes the new block minimum. A query takes two more divisions, then
// reads the partial-block elements at both ends plus the stored minimum of
// each whole block in between. The stores need no clearing after reset.
// Config writes (index 0 element count, 1 block size) are always accepted and
// must only be issued while the block is idle.
module range_min_sqrt_blocks_top
  import rmq_pkg::*;
#(
  parameter int unsigned MAX_ELEMS   = DEF_MAX_ELEMS,
  parameter int unsigned MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command side
  input  logic                 start_i,
  input  rmq_cmd_t             cmd_i,
  output logic                 busy_o,
  // result side
  output logic                 result_valid_o,
  output rmq_res_t             result_o,
  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [IDX_W-1:0]     cfg_data_i
);

  logic [IDX_W-1:0]       elem_count_q;
  logic [IDX_W-1:0]       blk_size_q;
  logic [VALUE_WIDTH-1:0] min_val;
  rmq_div_req_t           div_req;
  rmq_div_rsp_t           div_rsp;
  rmq_dp_ctl_t            dp_ctl;

  assign cfg_ready_o = 1'b1;

  // Config registers; unknown indices are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_count_q <= ELEM_COUNT_RST;
      blk_size_q   <= BLK_SIZE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ELEM_COUNT: elem_count_q <= cfg_data_i;
        REG_BLK_SIZE:   blk_size_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rmq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rmq_dp #(
    .MAX_ELEMS   (MAX_ELEMS),
    .MAX_BLOCKS  (MAX_BLOCKS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .ctl_i  (dp_ctl),
    .data_i (cmd_i.data_value),
    .min_o  (min_val)
  );

  rmq_ctrl #(
    .MAX_ELEMS   (MAX_ELEMS),
    .MAX_BLOCKS  (MAX_BLOCKS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .busy_o         (busy_o),
    .elem_count_i   (elem_count_q),
    .blk_size_i     (blk_size_q),
    .min_i          (min_val),
    .div_rsp_i      (div_rsp),
    .div_req_o      (div_req),
    .dp_ctl_o       (dp_ctl),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // An accepted word keeps the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after accepted word");

  // No result in the cycle right after a word is taken.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> !result_valid_o)
    else $error("result strobe right after accept");

  // Error results carry a zero minimum.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.error |-> result_o.min_value == '0)
    else $error("error result with nonzero min_value");

  // A result is only shown once the sequencer is back to idle.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobe while busy");

endmodule
